// ----- rtl/core/arm_operand2_barrel_shifter_macros.svh -----
// assertion macros shared by the operand 2 shifter checkers
// no dependencies; take in with an include of the bare file name
`ifndef ARM_OPERAND2_BARREL_SHIFTER_MACROS_SVH
`define ARM_OPERAND2_BARREL_SHIFTER_MACROS_SVH

// same-cycle implication, masked while reset is held
`define AOBS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("operand 2 shifter check failed");

// next-cycle implication, masked while reset is held
`define AOBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("operand 2 shifter check failed");

`endif

// ----- rtl/core/aobs_pkg.sv -----
// types and constants for the operand 2 barrel shifter
// no dependencies; used by the decoder, the shift unit and the top level
`timescale 1ns / 1ps

package aobs_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned AMT_W  = 8;

  localparam int unsigned BIT_S_POS   = 20;
  localparam int unsigned BIT_IMM_POS = 25;
  localparam int unsigned BIT_REG_POS = 4;

  localparam logic [1:0] TYPE_LSL = 2'd0;
  localparam logic [1:0] TYPE_LSR = 2'd1;
  localparam logic [1:0] TYPE_ASR = 2'd2;
  localparam logic [1:0] TYPE_ROR = 2'd3;

  localparam logic [AMT_W-1:0] AMT_FULL = 8'd32;

  typedef enum logic [2:0] {
    SH_LSL = 3'd0,
    SH_LSR = 3'd1,
    SH_ASR = 3'd2,
    SH_ROR = 3'd3,
    SH_RRX = 3'd4
  } shift_op_t;

  typedef struct packed {
    shift_op_t        op;
    logic [AMT_W-1:0] amt;
    logic             set_flags;
  } shift_ctl_t;

endpackage

// ----- rtl/core/aobs_decode.sv -----
// operand field decoder: picks the source value, shift kind and amount
// depends on aobs_pkg
`timescale 1ns / 1ps

module aobs_decode import aobs_pkg::*; (
  input  logic [WORD_W-1:0] instr_word,
  input  logic [WORD_W-1:0] rm_value,
  input  logic [AMT_W-1:0]  rs_low_byte,
  output logic [WORD_W-1:0] src,
  output shift_ctl_t        ctl
);

  logic [4:0] imm_amt;
  shift_op_t  type_op;

  assign imm_amt = instr_word[11:7];

  always_comb begin
    case (instr_word[6:5])
      TYPE_LSL: type_op = SH_LSL;
      TYPE_LSR: type_op = SH_LSR;
      TYPE_ASR: type_op = SH_ASR;
      TYPE_ROR: type_op = SH_ROR;
      default:  type_op = SH_LSL;
    endcase
  end

  always_comb begin
    ctl.set_flags = instr_word[BIT_S_POS];
    if (instr_word[BIT_IMM_POS]) begin
      // imm8 rotated right by twice the rotate field
      src     = {24'd0, instr_word[7:0]};
      ctl.op  = SH_ROR;
      ctl.amt = {3'd0, instr_word[11:8], 1'b0};
    end else if (instr_word[BIT_REG_POS]) begin
      src     = rm_value;
      ctl.op  = type_op;
      ctl.amt = rs_low_byte;
    end else begin
      src     = rm_value;
      ctl.op  = type_op;
      ctl.amt = {3'd0, imm_amt};
      if (imm_amt == 5'd0) begin
        case (type_op)
          SH_LSR, SH_ASR: ctl.amt = AMT_FULL;
          SH_ROR:         ctl.op  = SH_RRX;
          default:        ctl.amt = {3'd0, imm_amt};
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/aobs_shift.sv -----
// 32-bit barrel shift with carry out for lsl, lsr, asr, ror and rrx
// depends on aobs_pkg
`timescale 1ns / 1ps

module aobs_shift import aobs_pkg::*; (
  input  logic [WORD_W-1:0] src,
  input  shift_ctl_t        ctl,
  input  logic              carry_in,
  output logic [WORD_W-1:0] result,
  output logic              carry_out
);

  logic [4:0]        sh;
  logic              big;
  logic              full;
  logic [WORD_W:0]   lsl_t;
  logic [WORD_W:0]   lsr_t;
  logic [WORD_W:0]   asr_t;
  logic [2*WORD_W-1:0] ror_t;
  logic [WORD_W-1:0] fill;
  logic              sc;

  assign sh    = ctl.amt[4:0];
  assign big   = (ctl.amt > AMT_FULL);
  assign full  = (ctl.amt == AMT_FULL);
  assign lsl_t = {1'b0, src} << sh;
  assign lsr_t = {src, 1'b0} >> sh;
  assign asr_t = $unsigned($signed({src, 1'b0}) >>> sh);
  assign ror_t = {src, src} >> sh;
  assign fill  = {WORD_W{src[WORD_W-1]}};

  always_comb begin
    result = src;
    sc     = carry_in;
    if (ctl.op == SH_RRX) begin
      result = {carry_in, src[WORD_W-1:1]};
      sc     = src[0];
    end else if (ctl.amt != '0) begin
      case (ctl.op)
        SH_LSL: begin
          if (big) begin
            result = '0;
            sc     = 1'b0;
          end else if (full) begin
            result = '0;
            sc     = src[0];
          end else begin
            result = lsl_t[WORD_W-1:0];
            sc     = lsl_t[WORD_W];
          end
        end
        SH_LSR: begin
          if (big || full) begin
            result = '0;
            sc     = full & src[WORD_W-1];
          end else begin
            result = lsr_t[WORD_W:1];
            sc     = lsr_t[0];
          end
        end
        SH_ASR: begin
          if (big || full) begin
            result = fill;
            sc     = src[WORD_W-1];
          end else begin
            result = asr_t[WORD_W:1];
            sc     = asr_t[0];
          end
        end
        SH_ROR: begin
          // multiples of 32 leave the value and take bit 31 as carry
          result = ror_t[WORD_W-1:0];
          sc     = ror_t[WORD_W-1];
        end
        default: begin
          result = src;
          sc     = carry_in;
        end
      endcase
    end
  end

  assign carry_out = ctl.set_flags ? sc : carry_in;

endmodule

// ----- rtl/core/arm_operand2_barrel_shifter.sv -----
// throughput: one item per cycle; busy is low whenever reset is released
// the input register and the result register bound one shift pass
// out_valid strobes each result for one cycle; the receiver cannot stall
// rst_n is synchronous, active low, and clears both valid flags
`timescale 1ns / 1ps

module arm_operand2_barrel_shifter import aobs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] in_instr_word,
  input  logic [WORD_W-1:0] in_rm_value,
  input  logic [AMT_W-1:0]  in_rs_low_byte,
  input  logic              in_carry_in,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_operand_two,
  output logic              out_carry_out
);

  logic              in_vld_r, in_vld_nxt;
  logic [WORD_W-1:0] instr_r;
  logic [WORD_W-1:0] rm_r;
  logic [AMT_W-1:0]  rs_r;
  logic              cin_r;

  logic              out_vld_r, out_vld_nxt;
  logic [WORD_W-1:0] operand_r;
  logic              carry_r;

  logic [WORD_W-1:0] src;
  shift_ctl_t        ctl;
  logic [WORD_W-1:0] shift_val;
  logic              shift_c;

  assign busy        = ~rst_n;
  assign in_vld_nxt  = start & ~busy;
  assign out_vld_nxt = in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      instr_r <= in_instr_word;
      rm_r    <= in_rm_value;
      rs_r    <= in_rs_low_byte;
      cin_r   <= in_carry_in;
    end
    if (in_vld_r) begin
      operand_r <= shift_val;
      carry_r   <= shift_c;
    end
  end

  aobs_decode u_decode (
    .instr_word  (instr_r),
    .rm_value    (rm_r),
    .rs_low_byte (rs_r),
    .src         (src),
    .ctl         (ctl)
  );

  aobs_shift u_shift (
    .src       (src),
    .ctl       (ctl),
    .carry_in  (cin_r),
    .result    (shift_val),
    .carry_out (shift_c)
  );

  assign out_valid       = out_vld_r;
  assign out_operand_two = operand_r;
  assign out_carry_out   = carry_r;

endmodule

// ----- rtl/core/aobs_checker.sv -----
// port-level checks for the operand 2 shifter, bound to the top level
// depends on aobs_pkg and arm_operand2_barrel_shifter_macros.svh
`timescale 1ns / 1ps
`include "arm_operand2_barrel_shifter_macros.svh"

module aobs_checker import aobs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [WORD_W-1:0] in_instr_word,
  input logic              in_carry_in,
  input logic              out_valid,
  input logic [WORD_W-1:0] out_operand_two,
  input logic              out_carry_out
);

  logic              acc;
  logic              s_clr;
  logic              plain;
  logic              cin;
  logic              cout;
  logic [WORD_W-1:0] imm_val;
  logic [WORD_W-1:0] op2;

  assign acc     = start & ~busy;
  assign s_clr   = ~in_instr_word[BIT_S_POS];
  // immediate operand with a zero rotate field
  assign plain   = in_instr_word[BIT_IMM_POS] & (in_instr_word[11:8] == 4'd0);
  assign imm_val = {24'd0, in_instr_word[7:0]};
  assign cin     = in_carry_in;
  assign cout    = out_carry_out;
  assign op2     = out_operand_two;

  // every accepted item gives a result, and no result appears without an accepted item
  `AOBS_ASSERT_NEXT(a_result_follows, clk, rst_n, acc, ##1 out_valid)
  `AOBS_ASSERT_IMPLIES(a_no_spurious, clk, rst_n, out_valid, $past(acc, 2))
  // flags untouched when the s bit is clear
  `AOBS_ASSERT_IMPLIES(a_keep_c, clk, rst_n, out_valid && $past(s_clr, 2), cout == $past(cin, 2))
  // unrotated immediate is imm8 as is
  `AOBS_ASSERT_IMPLIES(a_imm0, clk, rst_n, out_valid && $past(plain, 2), op2 == $past(imm_val, 2))

endmodule

bind arm_operand2_barrel_shifter aobs_checker u_aobs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_instr_word   (in_instr_word),
  .in_carry_in     (in_carry_in),
  .out_valid       (out_valid),
  .out_operand_two (out_operand_two),
  .out_carry_out   (out_carry_out)
);
